### src/top_k_nearest_max_heap_defines.svh
// ----------------------------------------------------------------------------
// top_k_nearest_max_heap_defines
// Assertion macros used by the top-k selector RTL.
// ----------------------------------------------------------------------------
`ifndef TOP_K_NEAREST_MAX_HEAP_DEFINES_SVH
`define TOP_K_NEAREST_MAX_HEAP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TKN_ASSERT_IMPL(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("top-k selector: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define TKN_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("top-k selector: next-cycle check failed");

`endif

### src/tkn_pkg.sv
// ----------------------------------------------------------------------------
// tkn_pkg
// Types and constants of the top-k nearest selector.
// ----------------------------------------------------------------------------
package tkn_pkg;

    // Width of the rank field on the result channel
    localparam int unsigned RANK_W = 5;

    // Request function codes
    localparam logic FUNC_OFFER = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP,
        ST_UP_CMP,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_DN_DEC,
        ST_DR_HEAD,
        ST_DR_SCAN,
        ST_DR_PUT,
        ST_DR_SWP,
        ST_DR_EMPTY
    } t_state;

endpackage

### src/top_k_nearest_max_heap.sv
// ----------------------------------------------------------------------------
// top_k_nearest_max_heap
// Keeps the NEIGHBOR_COUNT smallest squared distances with their ids in a
// max-heap held in one RAM, and drains them in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready): i_func = 0 offers a candidate,
//   taken only when i_dark_matter = 1; i_func = 1 drains and clears the store.
//   Result channel (o_out_valid / i_out_ready): drains only. One result per
//   stored entry, rank 0 closest, o_last on the final one; an empty store
//   gives one result with o_empty_res = 1 and zero fields.
//   Handshake: o_in_ready is high only while the sequencer is idle, so a new
//   request is taken only once the previous one is done. All heap reads
//   go through the single RAM read port (registered read) and one shared
//   distance comparator.
//   Offer while filling: the candidate climbs from the next free slot,
//   moving each smaller parent down, until it settles or reaches the root.
//   Offer when full: a candidate closer than the root replaces it and sifts
//   down, swapping with its larger child, until it settles or hits a leaf.
//   Drain of n entries: pass i scans the n-i entries from slot i, outputs
//   the smallest, and swaps it with the entry in slot i where they differ.
//   A stalled receiver holds the result register and freezes the drain; the
//   last result may wait in it while new offers are taken.
//   Reset empties the store at once (fill count to zero, no clearing pass).
// ----------------------------------------------------------------------------
`include "top_k_nearest_max_heap_defines.svh"

module top_k_nearest_max_heap #(
    parameter int unsigned NEIGHBOR_COUNT = 32,
    parameter int unsigned ID_BITS        = 24,
    parameter int unsigned DIST_BITS      = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic [ID_BITS-1:0]          i_item_id,
    input  logic [DIST_BITS-1:0]        i_distance_sq,
    input  logic                        i_dark_matter,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ID_BITS-1:0]          o_neighbor_id,
    output logic [DIST_BITS-1:0]        o_neighbor_distance_sq,
    output logic [tkn_pkg::RANK_W-1:0]  o_rank,
    output logic                        o_empty_res,
    output logic                        o_last
);

    import tkn_pkg::*;

    localparam int unsigned IDX_W  = $clog2(NEIGHBOR_COUNT);
    localparam int unsigned CNT_W  = IDX_W + 1;
    localparam int unsigned WORD_W = ID_BITS + DIST_BITS;
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(NEIGHBOR_COUNT);

    t_state r_state, n_state;

    // control
    logic [CNT_W-1:0]     r_fill;
    logic                 r_out_valid;
    // datapath
    logic [IDX_W-1:0]     r_pos, r_i, r_min_idx, r_best_idx, r_rq;
    logic [CNT_W-1:0]     r_j;
    logic                 r_first;
    logic [ID_BITS-1:0]   r_cur_id, r_best_id, r_min_id, r_head_id;
    logic [DIST_BITS-1:0] r_cur_dist, r_best_dist, r_min_dist, r_head_dist, r_root_dist;
    logic [ID_BITS-1:0]   r_out_id;
    logic [DIST_BITS-1:0] r_out_dist;
    logic [RANK_W-1:0]    r_out_rank;
    logic                 r_out_empty, r_out_last;

    // RAM port
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0]    ram_wdata, ram_rdata;
    logic [ID_BITS-1:0]   rd_id;
    logic [DIST_BITS-1:0] rd_dist;

    // misc decode
    logic                 in_acc, out_free, out_load, full, last_pass;
    logic [IDX_W-1:0]     pos_parent;
    logic [CNT_W-1:0]     child_l, child_r;
    logic [IDX_W+RANK_W-1:0] rank_ext;
    logic [DIST_BITS-1:0] cmp_a, cmp_b;
    logic                 cmp_gt;

    tkn_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NEIGHBOR_COUNT)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_id   = ram_rdata[WORD_W-1:DIST_BITS];
    assign rd_dist = ram_rdata[DIST_BITS-1:0];

    assign in_acc     = i_in_valid & o_in_ready;
    assign out_free   = ~r_out_valid | i_out_ready;
    assign out_load   = ((r_state == ST_DR_PUT) || (r_state == ST_DR_EMPTY)) && out_free;
    assign full       = (r_fill == N_CNT);
    assign last_pass  = ({1'b0, r_i} == (r_fill - 1'b1));
    assign pos_parent = (r_pos - 1'b1) >> 1;
    assign child_l    = {r_pos, 1'b1};
    assign child_r    = child_l + 1'b1;
    assign rank_ext   = {{RANK_W{1'b0}}, r_i};

    // Shared distance comparator: cmp_gt = a > b
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (r_state)
            ST_IDLE: begin
                cmp_a = r_root_dist;
                cmp_b = i_distance_sq;
            end
            ST_UP_CMP: begin
                cmp_a = r_cur_dist;
                cmp_b = rd_dist;
            end
            ST_DN_RDR, ST_DN_CMP: begin
                cmp_a = rd_dist;
                cmp_b = r_best_dist;
            end
            ST_DR_SCAN: begin
                cmp_a = r_min_dist;
                cmp_b = rd_dist;
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end
    assign cmp_gt = (cmp_a > cmp_b);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_func == FUNC_DRAIN) begin
                        n_state = (r_fill == '0) ? ST_DR_EMPTY : ST_DR_HEAD;
                    end else if (i_dark_matter) begin
                        if (!full) begin
                            n_state = ST_UP;
                        end else if (cmp_gt) begin
                            n_state = ST_DN_RDL;
                        end
                    end
                end
            end
            ST_UP:       n_state = (r_pos == '0) ? ST_IDLE : ST_UP_CMP;
            ST_UP_CMP:   n_state = cmp_gt ? ST_UP : ST_IDLE;
            ST_DN_RDL:   n_state = (child_l < N_CNT) ? ST_DN_RDR : ST_IDLE;
            ST_DN_RDR:   n_state = (child_r < N_CNT) ? ST_DN_CMP : ST_DN_DEC;
            ST_DN_CMP:   n_state = ST_DN_DEC;
            ST_DN_DEC:   n_state = (r_best_idx == r_pos) ? ST_IDLE : ST_DN_RDL;
            ST_DR_HEAD:  n_state = ST_DR_SCAN;
            ST_DR_SCAN:  n_state = (r_j < r_fill) ? ST_DR_SCAN : ST_DR_PUT;
            ST_DR_PUT: begin
                if (out_free) begin
                    if (r_min_idx != r_i) begin
                        n_state = ST_DR_SWP;
                    end else begin
                        n_state = last_pass ? ST_IDLE : ST_DR_HEAD;
                    end
                end
            end
            ST_DR_SWP:   n_state = last_pass ? ST_IDLE : ST_DR_HEAD;
            ST_DR_EMPTY: n_state = out_free ? ST_IDLE : ST_DR_EMPTY;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: RAM controls and request ready
    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_pos;
        ram_wdata  = {r_cur_id, r_cur_dist};
        ram_raddr  = r_pos;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_UP: begin
                if (r_pos == '0) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = pos_parent;
                end
            end
            ST_UP_CMP: begin
                // parent moves down into the hole, or the candidate settles
                ram_we = 1'b1;
                if (cmp_gt) begin
                    ram_wdata = ram_rdata;
                end
            end
            ST_DN_RDL: begin
                if (child_l < N_CNT) begin
                    ram_raddr = child_l[IDX_W-1:0];
                end else begin
                    ram_we = 1'b1;
                end
            end
            ST_DN_RDR: ram_raddr = child_r[IDX_W-1:0];
            ST_DN_CMP: ram_raddr = r_pos;
            ST_DN_DEC: begin
                ram_we = 1'b1;
                if (r_best_idx != r_pos) begin
                    ram_wdata = {r_best_id, r_best_dist};
                end
            end
            ST_DR_HEAD: ram_raddr = r_i;
            ST_DR_SCAN: ram_raddr = r_j[IDX_W-1:0];
            ST_DR_PUT: begin
                ram_we    = out_free;
                ram_waddr = r_i;
                ram_wdata = {r_min_id, r_min_dist};
            end
            ST_DR_SWP: begin
                ram_we    = 1'b1;
                ram_waddr = r_min_idx;
                ram_wdata = {r_head_id, r_head_dist};
            end
            ST_DR_EMPTY: ram_we = 1'b0;
            default: ram_we = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && in_acc && i_func == FUNC_OFFER && i_dark_matter
                    && !full) begin
                r_fill <= r_fill + 1'b1;
            end else if ((r_state == ST_DR_PUT || r_state == ST_DR_SWP)
                    && n_state == ST_IDLE) begin
                r_fill <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // heap root tracks every write to slot zero
        if (ram_we && ram_waddr == '0) begin
            r_root_dist <= ram_wdata[DIST_BITS-1:0];
        end

        case (r_state)
            ST_IDLE: begin
                r_cur_id   <= i_item_id;
                r_cur_dist <= i_distance_sq;
                r_pos      <= full ? '0 : r_fill[IDX_W-1:0];
                r_i        <= '0;
            end
            ST_UP_CMP: begin
                if (cmp_gt) begin
                    r_pos <= pos_parent;
                end
            end
            ST_DN_RDL: begin
                r_best_id   <= r_cur_id;
                r_best_dist <= r_cur_dist;
                r_best_idx  <= r_pos;
            end
            ST_DN_RDR: begin
                if (cmp_gt) begin
                    r_best_id   <= rd_id;
                    r_best_dist <= rd_dist;
                    r_best_idx  <= child_l[IDX_W-1:0];
                end
            end
            ST_DN_CMP: begin
                if (cmp_gt) begin
                    r_best_id   <= rd_id;
                    r_best_dist <= rd_dist;
                    r_best_idx  <= child_r[IDX_W-1:0];
                end
            end
            ST_DN_DEC: r_pos <= r_best_idx;
            ST_DR_HEAD: begin
                r_rq    <= r_i;
                r_j     <= {1'b0, r_i} + 1'b1;
                r_first <= 1'b1;
            end
            ST_DR_SCAN: begin
                // running minimum, earliest slot wins ties
                r_first <= 1'b0;
                if (r_first) begin
                    r_min_id    <= rd_id;
                    r_min_dist  <= rd_dist;
                    r_min_idx   <= r_rq;
                    r_head_id   <= rd_id;
                    r_head_dist <= rd_dist;
                end else if (cmp_gt) begin
                    r_min_id   <= rd_id;
                    r_min_dist <= rd_dist;
                    r_min_idx  <= r_rq;
                end
                if (r_j < r_fill) begin
                    r_rq <= r_j[IDX_W-1:0];
                    r_j  <= r_j + 1'b1;
                end
            end
            ST_DR_PUT, ST_DR_SWP: begin
                if (n_state == ST_DR_HEAD) begin
                    r_i <= r_i + 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Result register
        if (out_load) begin
            if (r_state == ST_DR_PUT) begin
                r_out_id    <= r_min_id;
                r_out_dist  <= r_min_dist;
                r_out_rank  <= rank_ext[RANK_W-1:0];
                r_out_empty <= 1'b0;
                r_out_last  <= last_pass;
            end else begin
                r_out_id    <= '0;
                r_out_dist  <= '0;
                r_out_rank  <= '0;
                r_out_empty <= 1'b1;
                r_out_last  <= 1'b1;
            end
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_neighbor_id          = r_out_id;
    assign o_neighbor_distance_sq = r_out_dist;
    assign o_rank                 = r_out_rank;
    assign o_empty_res            = r_out_empty;
    assign o_last                 = r_out_last;

    // Checks
    `TKN_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= N_CNT)
    `TKN_ASSERT_IMPL(a_write_in_fill, i_clk, i_rst_n, ram_we, {1'b0, ram_waddr} < r_fill)
    `TKN_ASSERT_IMPL(a_empty_only_when_empty, i_clk, i_rst_n, r_state == ST_DR_EMPTY, r_fill == '0)
    `TKN_ASSERT_NEXT(a_drain_starts_scan, i_clk, i_rst_n, in_acc && i_func == FUNC_DRAIN && r_fill != '0, r_state == ST_DR_HEAD)

endmodule

### src/tkn_ram.sv
// ----------------------------------------------------------------------------
// tkn_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tkn_ram #(
    parameter int unsigned WIDTH = 56,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
